// ----- design/hlr_pkg.sv -----
// Package for the hex line rasterizer: default sizes and sequencer states.
`default_nettype none
package hlr_pkg;

  localparam int MAX_LINE_DEF   = 64;
  localparam int COORD_BITS_DEF = 10;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIST = 3'b010,
    ST_EMIT = 3'b100
  } hlr_state_t;

endpackage
`default_nettype wire

// ----- design/hex_line_rasterizer.sv -----
// Top level of the hex line rasterizer: distance, then one line cell per cycle unless m_tready stalls.
`default_nettype none
// Hex line rasterizer. Each input transaction carries a start and an end cell
// in axial coordinates (q, r); the block answers with the N+1 cells of the hex
// line between them, N being the hex distance, start first and end last, with
// tlast set on the final cell. Half-way points round up in q and r and down in
// s, and the coordinate with the largest rounding error is rebuilt from the
// other two. A line with N >= MAX_LINE yields a single transaction with tuser
// (too_long) and tlast set and zero coordinates. The input is captured in
// ST_IDLE and the distance is found in ST_DIST; then ST_EMIT gives one cell
// per cycle while the output side keeps taking them. The cells come from three
// small remainder accumulators, one per cube coordinate, each advanced by its
// own add-and-correct step under the sequencer, Bresenham style; no multiply
// or divide is used. s_tready is high only while the sequencer is idle;
// coordinates wrap in two's complement at COORD_BITS.
module hex_line_rasterizer
  import hlr_pkg::*;
#(
  parameter int MAX_LINE   = MAX_LINE_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // start_q, start_r, end_q, end_r, from the lowest bit up
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // cell_q, cell_r, from the lowest bit up, zero padded
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tlast,
  // too_long
  output logic                  m_tuser
);

  localparam int CB = COORD_BITS;
  localparam int SW = CB + 1;              // span width
  localparam int DW = $clog2(MAX_LINE);    // distance width, holds 0..MAX_LINE-1
  localparam int EW = DW + 3;              // remainder width, holds [-2d, 4d)

  hlr_state_t state;

  // Captured endpoints
  logic signed [CB-1:0] start_q, start_r, end_q, end_r;

  // Line state
  logic signed [SW-1:0] span_q, span_r;
  logic [DW-1:0]        line_distance;
  logic [DW-1:0]        step_index;

  // Per-coordinate accumulators: q, r and minus s
  logic signed [CB-1:0] acc [3];
  logic signed [EW-1:0] rem [3];

  // Output register
  logic signed [CB-1:0] cell_q, cell_r;

  // ---------------------------------------------------------------------
  // Distance: N = (|dq| + |dr| + |ds|) / 2
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] dq, dr;
  logic signed [SW:0]   ds;
  logic [SW:0]          abs_q, abs_r, abs_s;
  logic [SW+1:0]        dist_sum;
  logic [SW:0]          dist_full;
  logic                 too_long;
  logic [DW-1:0]        dist_n;
  logic signed [EW-1:0] dist_d;

  always_comb begin
    dq        = SW'(end_q) - SW'(start_q);
    dr        = SW'(end_r) - SW'(start_r);
    ds        = -((SW+1)'(dq) + (SW+1)'(dr));
    abs_q     = dq[SW-1] ? (SW+1)'(-(SW+1)'(dq)) : (SW+1)'(dq);
    abs_r     = dr[SW-1] ? (SW+1)'(-(SW+1)'(dr)) : (SW+1)'(dr);
    abs_s     = ds[SW]   ? (SW+1)'(-ds)          : (SW+1)'(ds);
    dist_sum  = (SW+2)'(abs_q) + (SW+2)'(abs_r) + (SW+2)'(abs_s);
    dist_full = dist_sum[SW+1:1];
    too_long  = 32'(dist_full) >= MAX_LINE;
    dist_n    = dist_full[DW-1:0];
    dist_d    = (dist_n == '0) ? EW'(1) : $signed(EW'(dist_n));
  end

  // ---------------------------------------------------------------------
  // Step unit: advance each remainder by twice the span, correct once
  // ---------------------------------------------------------------------
  logic signed [EW-1:0] line_d, line_d2;
  logic signed [EW-1:0] delta   [3];
  logic signed [EW-1:0] rem_sum [3];
  logic signed [EW-1:0] rem_next [3];
  logic signed [CB-1:0] acc_next [3];
  logic signed [EW-1:0] diff [3];
  logic [EW-1:0]        err  [3];
  logic                 q_big, r_big;
  logic signed [CB-1:0] out_q, out_r;

  always_comb begin
    line_d   = (line_distance == '0) ? EW'(1) : $signed(EW'(line_distance));
    line_d2  = line_d <<< 1;
    delta[0] = EW'(span_q);
    delta[1] = EW'(span_r);
    delta[2] = EW'(span_q) + EW'(span_r);
    for (int k = 0; k < 3; k++) begin
      rem_sum[k] = rem[k] + (delta[k] <<< 1);
      if (rem_sum[k] >= line_d2) begin
        rem_next[k] = rem_sum[k] - line_d2;
        acc_next[k] = acc[k] + CB'(1);
      end else if (rem_sum[k] < 0) begin
        rem_next[k] = rem_sum[k] + line_d2;
        acc_next[k] = acc[k] - CB'(1);
      end else begin
        rem_next[k] = rem_sum[k];
        acc_next[k] = acc[k];
      end
      // the rounding error of this coordinate, scaled by 2d
      diff[k] = line_d - rem[k];
      err[k]  = diff[k][EW-1] ? EW'(-diff[k]) : EW'(diff[k]);
    end
    // rebuild the worst coordinate from the other two (acc[2] is minus s)
    q_big = (err[0] > err[1]) && (err[0] > err[2]);
    r_big = !q_big && (err[1] > err[2]);
    out_q = q_big ? (acc[2] - acc[1]) : acc[0];
    out_r = r_big ? (acc[2] - acc[0]) : acc[1];
  end

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  logic out_free;
  logic out_load;
  logic last_cell;

  assign out_free  = !m_tvalid || m_tready;
  // load the output register with a cell or with the too-long flag
  assign out_load  = ((state == ST_DIST) && too_long && out_free) ||
                     ((state == ST_EMIT) && out_free);
  assign last_cell = step_index == line_distance;
  assign s_tready  = state == ST_IDLE;
  assign m_tdata   = OUT_W'({cell_r, cell_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      m_tlast       <= 1'b0;
      m_tuser       <= 1'b0;
      span_q        <= '0;
      span_r        <= '0;
      line_distance <= '0;
      step_index    <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (too_long) begin
            // hold until the output slot frees, then flag the line
            if (out_free) begin
              m_tlast  <= 1'b1;
              m_tuser  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            span_q        <= dq;
            span_r        <= dr;
            line_distance <= dist_n;
            step_index    <= '0;
            state         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tlast  <= last_cell;
            m_tuser  <= 1'b0;
            if (last_cell) begin
              state <= ST_IDLE;
            end else begin
              step_index <= step_index + DW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: endpoints, accumulators, cell values
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          start_q <= s_tdata[CB-1:0];
          start_r <= s_tdata[2*CB-1:CB];
          end_q   <= s_tdata[3*CB-1:2*CB];
          end_r   <= s_tdata[4*CB-1:3*CB];
        end
      end
      ST_DIST: begin
        // cell 0 is the start cell; every remainder starts at d
        acc[0] <= start_q;
        acc[1] <= start_r;
        acc[2] <= start_q + start_r;
        for (int k = 0; k < 3; k++) begin
          rem[k] <= dist_d;
        end
        if (too_long && out_free) begin
          cell_q <= '0;
          cell_r <= '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cell_q <= out_q;
          cell_r <= out_r;
          for (int k = 0; k < 3; k++) begin
            acc[k] <= acc_next[k];
            rem[k] <= rem_next[k];
          end
        end
      end
      default: begin
        cell_q <= cell_q;
      end
    endcase
  end

endmodule
`default_nettype wire
